[sv/dag_topo_sort_longest_path_defines.svh]
// Assertion macros used by the top RTL file of the graph sort block.
`ifndef DAG_TOPO_SORT_LONGEST_PATH_DEFINES_SVH
`define DAG_TOPO_SORT_LONGEST_PATH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DTSL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtsl same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DTSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtsl next-cycle check failed");

`endif

[sv/dtsl_pkg.sv]
package dtsl_pkg;

   localparam int NODES_DEFAULT = 64;
   localparam int DIST_W        = 6;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   localparam logic [2:0] OP_ADD_EDGE    = 3'd0;
   localparam logic [2:0] OP_REMOVE_EDGE = 3'd1;
   localparam logic [2:0] OP_REMOVE_NODE = 3'd2;
   localparam logic [2:0] OP_SORT        = 3'd3;
   localparam logic [2:0] OP_DIST_SINK   = 3'd4;
   localparam logic [2:0] OP_DIST_SOURCE = 3'd5;

   localparam logic [1:0] COLOR_WHITE = 2'd0;
   localparam logic [1:0] COLOR_GRAY  = 2'd1;
   localparam logic [1:0] COLOR_BLACK = 2'd2;

   // Result of the shared saturating increment and compare unit.
   typedef struct packed {
      logic [DIST_W-1:0] sum;
      logic              gt;
   } alu_res_type;

endpackage

[sv/dtsl_ram.sv]
module dtsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/dtsl_alu.sv]
module dtsl_alu (
   input  logic [dtsl_pkg::DIST_W-1:0] base,
   input  logic [dtsl_pkg::DIST_W-1:0] cmp,
   output dtsl_pkg::alu_res_type       res
);

   import dtsl_pkg::*;

   // One more edge on a path, held at the largest distance, then compared.
   always_comb begin
      res.sum = (base == DIST_MAX) ? base : base + DIST_W'(1);
      res.gt  = res.sum > cmp;
   end

endmodule

[sv/dag_topo_sort_longest_path.sv]
// Directed graph store with depth-first topological sort and longest paths.
// Input channel req_: one beat carries op, node_a and node_b. Result channel
// rsp_: exactly one beat per input beat, in order, with status, acyclic,
// reached and distance. Both channels use valid/ready.
// Edge add and remove read the row of node_a and write it back; node removal
// reads and rewrites every row in turn; distance-to-sink reads one word. A
// sort clears the colors, then scans one adjacency bit per cycle for every
// visited node, pausing in a further state on each edge found, and scans the
// row of each finished node but the first once more for the sink distance.
// A distance-from-source query clears the source distances, then walks the
// recorded order, scanning NODES row bits per reached node plus an update
// step per edge. The single adjacency read port and the one-bit-per-cycle
// scan set the pace of these operations. One item is worked at a time.
// After reset the block sweeps all NODES rows to clear the adjacency and
// distance-to-sink memories with req_ready low.
// A finished result waits in an output register while the next beat may be
// accepted; a new result is held back only while that register is full.
`include "dag_topo_sort_longest_path_defines.svh"

module dag_topo_sort_longest_path #(
   parameter int NODES = dtsl_pkg::NODES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_op,
   input  logic [5:0]                  req_node_a,
   input  logic [5:0]                  req_node_b,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_status,
   output logic                        rsp_acyclic,
   output logic                        rsp_reached,
   output logic [dtsl_pkg::DIST_W-1:0] rsp_distance
);

   import dtsl_pkg::*;

   localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CW = NW + 1;

   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE, ST_EDGE_WR, ST_RM_RD, ST_RM_WR, ST_DTS_RD,
      ST_S_CLR, ST_S_GRAY, ST_S_ROW, ST_S_ROWW, ST_S_SCAN, ST_S_COL,
      ST_S_FIN, ST_S_FIND, ST_S_POP,
      ST_R_CLR, ST_R_FIRST, ST_R_NEXT, ST_R_U, ST_R_UW, ST_R_SCAN, ST_R_UPD,
      ST_R_ANS, ST_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [NW-1:0]     top_u_ff, top_u_in;
   logic [CW-1:0]     top_v_ff, top_v_in;
   logic [CW-1:0]     sp_ff, sp_in;
   logic [CW-1:0]     ol_ff, ol_in;
   logic [CW-1:0]     k_ff, k_in;
   logic              acyclic_ff, acyclic_in;
   logic [NODES-1:0]  row_ff, row_in;
   logic [DIST_W-1:0] dmax_ff, dmax_in;
   logic [DIST_W-1:0] du_ff, du_in;
   logic              pend_ff, pend_in;
   logic [2:0]        op_ff, op_in;
   logic [NW-1:0]     a_ff, a_in;
   logic [NW-1:0]     b_ff, b_in;
   logic              a_ok_ff, a_ok_in;
   logic              res_status_ff, res_status_in;
   logic              res_reached_ff, res_reached_in;
   logic [DIST_W-1:0] res_dist_ff, res_dist_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_acyclic_ff, rsp_acyclic_in;
   logic              rsp_reached_ff, rsp_reached_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;

   // Memory ports.
   logic              adj_we;
   logic [NW-1:0]     adj_waddr, adj_raddr;
   logic [NODES-1:0]  adj_wdata, adj_rdata;
   logic              col_we;
   logic [NW-1:0]     col_waddr, col_raddr;
   logic [1:0]        col_wdata, col_rdata;
   logic              dts_we;
   logic [NW-1:0]     dts_waddr, dts_raddr;
   logic [DIST_W-1:0] dts_wdata, dts_rdata;
   logic              topo_we;
   logic [NW-1:0]     topo_waddr, topo_raddr;
   logic [NW-1:0]     topo_wdata, topo_rdata;
   logic              stk_we;
   logic [NW-1:0]     stk_waddr, stk_raddr;
   logic [NW+CW-1:0]  stk_wdata, stk_rdata;
   logic              src_we;
   logic [NW-1:0]     src_waddr, src_raddr;
   logic [DIST_W:0]   src_wdata, src_rdata;

   logic [DIST_W-1:0] alu_base, alu_cmp;
   alu_res_type       alu_res;

   logic [NW-1:0]     idx;
   logic              last;
   logic              accept;
   logic              req_a_ok, req_b_ok;
   logic [CW-1:0]     sp_m1, sp_m2, ol_m1, k_m1;
   logic [DIST_W-1:0] d_final;

   assign idx      = cnt_ff[NW-1:0];
   assign last     = cnt_ff == CW'(NODES - 1);
   assign accept   = req_valid && req_ready;
   assign req_a_ok = 32'(req_node_a) < NODES;
   assign req_b_ok = 32'(req_node_b) < NODES;
   assign sp_m1    = sp_ff - CW'(1);
   assign sp_m2    = sp_ff - CW'(2);
   assign ol_m1    = ol_ff - CW'(1);
   assign k_m1     = k_ff - CW'(1);
   assign req_ready = state_ff == ST_IDLE;

   // The shared unit serves the sink-distance maximum during a sort and the
   // source-distance relaxation during a query.
   always_comb begin
      if (state_ff == ST_R_UPD) begin
         alu_base = du_ff;
         alu_cmp  = src_rdata[DIST_W-1:0];
      end else begin
         alu_base = dts_rdata;
         alu_cmp  = dmax_ff;
      end
   end

   dtsl_alu u_alu (.base(alu_base), .cmp(alu_cmp), .res(alu_res));

   assign d_final = (pend_ff && alu_res.gt) ? alu_res.sum : dmax_ff;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      top_u_in       = top_u_ff;
      top_v_in       = top_v_ff;
      sp_in          = sp_ff;
      ol_in          = ol_ff;
      k_in           = k_ff;
      acyclic_in     = acyclic_ff;
      row_in         = row_ff;
      dmax_in        = dmax_ff;
      du_in          = du_ff;
      pend_in        = pend_ff;
      op_in          = op_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      a_ok_in        = a_ok_ff;
      res_status_in  = res_status_ff;
      res_reached_in = res_reached_ff;
      res_dist_in    = res_dist_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_acyclic_in = rsp_acyclic_ff;
      rsp_reached_in = rsp_reached_ff;
      rsp_dist_in    = rsp_dist_ff;

      adj_we = 1'b0;  adj_waddr = idx;  adj_wdata = '0;  adj_raddr = idx;
      col_we = 1'b0;  col_waddr = idx;  col_wdata = COLOR_WHITE;
      col_raddr = top_v_ff[NW-1:0];
      dts_we = 1'b0;  dts_waddr = top_u_ff;  dts_wdata = d_final;  dts_raddr = idx;
      topo_we = 1'b0; topo_waddr = ol_ff[NW-1:0]; topo_wdata = top_u_ff;
      topo_raddr = k_m1[NW-1:0];
      stk_we = 1'b0;  stk_waddr = sp_m1[NW-1:0];
      stk_wdata = {top_u_ff, top_v_ff + CW'(1)};
      stk_raddr = sp_m2[NW-1:0];
      src_we = 1'b0;  src_waddr = idx;  src_wdata = '0;  src_raddr = idx;

      unique case (state_ff)
         ST_INIT: begin
            adj_we = 1'b1;
            dts_we = 1'b1;
            dts_waddr = idx;
            dts_wdata = '0;
            if (last) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in          = req_op;
               a_in           = NW'(req_node_a);
               b_in           = NW'(req_node_b);
               a_ok_in        = req_a_ok;
               res_status_in  = 1'b0;
               res_reached_in = 1'b0;
               res_dist_in    = '0;
               cnt_in         = '0;
               adj_raddr      = NW'(req_node_a);
               dts_raddr      = NW'(req_node_a);
               state_in       = ST_RESP;
               priority case (req_op)
                  OP_ADD_EDGE, OP_REMOVE_EDGE: begin
                     if (req_a_ok && req_b_ok) state_in = ST_EDGE_WR;
                  end
                  OP_REMOVE_NODE: begin
                     if (req_a_ok) state_in = ST_RM_RD;
                  end
                  OP_SORT: begin
                     if (req_a_ok) state_in = ST_S_CLR;
                  end
                  OP_DIST_SINK: begin
                     if (req_a_ok) state_in = ST_DTS_RD;
                  end
                  OP_DIST_SOURCE: begin
                     if (ol_ff == '0) begin
                        res_status_in = 1'b1;
                     end else begin
                        state_in = ST_R_CLR;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_EDGE_WR: begin
            adj_we    = 1'b1;
            adj_waddr = a_ff;
            adj_wdata = adj_rdata;
            adj_wdata[b_ff] = (op_ff == OP_ADD_EDGE);
            state_in  = ST_RESP;
         end
         ST_RM_RD: begin
            state_in = ST_RM_WR;
         end
         ST_RM_WR: begin
            adj_we = 1'b1;
            if (idx != a_ff) begin
               adj_wdata = adj_rdata;
               adj_wdata[a_ff] = 1'b0;
            end
            if (last) begin
               state_in = ST_RESP;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = ST_RM_RD;
            end
         end
         ST_DTS_RD: begin
            res_dist_in = dts_rdata;
            state_in    = ST_RESP;
         end
         ST_S_CLR: begin
            col_we = 1'b1;
            if (last) begin
               ol_in      = '0;
               acyclic_in = 1'b1;
               sp_in      = CW'(1);
               top_u_in   = a_ff;
               top_v_in   = '0;
               state_in   = ST_S_GRAY;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_S_GRAY: begin
            col_we    = 1'b1;
            col_waddr = a_ff;
            col_wdata = COLOR_GRAY;
            adj_raddr = top_u_ff;
            state_in  = ST_S_ROWW;
         end
         ST_S_ROW: begin
            adj_raddr = top_u_ff;
            state_in  = ST_S_ROWW;
         end
         ST_S_ROWW: begin
            row_in   = adj_rdata;
            state_in = ST_S_SCAN;
         end
         ST_S_SCAN: begin
            if (top_v_ff == CW'(NODES)) begin
               // Every neighbor has been looked at: the node finishes.
               col_we    = 1'b1;
               col_waddr = top_u_ff;
               col_wdata = COLOR_BLACK;
               dmax_in   = '0;
               pend_in   = 1'b0;
               cnt_in    = '0;
               state_in  = (ol_ff != '0) ? ST_S_FIN : ST_S_FIND;
            end else if (row_ff[top_v_ff[NW-1:0]]) begin
               state_in = ST_S_COL;
            end else begin
               top_v_in = top_v_ff + CW'(1);
            end
         end
         ST_S_COL: begin
            top_v_in = top_v_ff + CW'(1);
            state_in = ST_S_SCAN;
            if (col_rdata == COLOR_WHITE) begin
               if (sp_ff < CW'(NODES)) begin
                  col_we    = 1'b1;
                  col_waddr = top_v_ff[NW-1:0];
                  col_wdata = COLOR_GRAY;
                  stk_we    = 1'b1;
                  top_u_in  = top_v_ff[NW-1:0];
                  top_v_in  = '0;
                  sp_in     = sp_ff + CW'(1);
                  state_in  = ST_S_ROW;
               end
            end else if (col_rdata == COLOR_GRAY) begin
               acyclic_in = 1'b0;
            end
         end
         ST_S_FIN: begin
            pend_in = row_ff[idx];
            if (pend_ff && alu_res.gt) dmax_in = alu_res.sum;
            if (last) begin
               state_in = ST_S_FIND;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_S_FIND: begin
            dts_we  = 1'b1;
            pend_in = 1'b0;
            if (ol_ff < CW'(NODES)) begin
               topo_we = 1'b1;
               ol_in   = ol_ff + CW'(1);
            end
            sp_in = sp_m1;
            state_in = (sp_ff == CW'(1)) ? ST_RESP : ST_S_POP;
         end
         ST_S_POP: begin
            top_u_in = stk_rdata[NW+CW-1:CW];
            top_v_in = stk_rdata[CW-1:0];
            state_in = ST_S_ROW;
         end
         ST_R_CLR: begin
            src_we = 1'b1;
            topo_raddr = ol_m1[NW-1:0];
            if (last) begin
               state_in = ST_R_FIRST;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_R_FIRST: begin
            src_we    = 1'b1;
            src_waddr = topo_rdata;
            src_wdata = {1'b1, {DIST_W{1'b0}}};
            k_in      = ol_ff;
            state_in  = ST_R_NEXT;
         end
         ST_R_NEXT: begin
            src_raddr = a_ff;
            if (k_ff == '0) begin
               state_in = a_ok_ff ? ST_R_ANS : ST_RESP;
            end else begin
               state_in = ST_R_U;
            end
         end
         ST_R_U: begin
            top_u_in  = topo_rdata;
            src_raddr = topo_rdata;
            adj_raddr = topo_rdata;
            state_in  = ST_R_UW;
         end
         ST_R_UW: begin
            if (!src_rdata[DIST_W]) begin
               k_in     = k_m1;
               state_in = ST_R_NEXT;
            end else begin
               du_in    = src_rdata[DIST_W-1:0];
               row_in   = adj_rdata;
               cnt_in   = '0;
               state_in = ST_R_SCAN;
            end
         end
         ST_R_SCAN: begin
            if (row_ff[idx]) begin
               state_in = ST_R_UPD;
            end else if (last) begin
               k_in     = k_m1;
               state_in = ST_R_NEXT;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_R_UPD: begin
            if (!src_rdata[DIST_W] || alu_res.gt) begin
               src_we    = 1'b1;
               src_wdata = {1'b1, alu_res.sum};
               // A self loop raises the distance used for later neighbors.
               if (idx == top_u_ff) du_in = alu_res.sum;
            end
            if (last) begin
               k_in     = k_m1;
               state_in = ST_R_NEXT;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = ST_R_SCAN;
            end
         end
         ST_R_ANS: begin
            if (src_rdata[DIST_W]) begin
               res_reached_in = 1'b1;
               res_dist_in    = src_rdata[DIST_W-1:0];
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_acyclic_in = acyclic_ff;
               rsp_reached_in = res_reached_ff;
               rsp_dist_in    = res_dist_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         sp_ff        <= '0;
         ol_ff        <= '0;
         k_ff         <= '0;
         acyclic_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sp_ff        <= sp_in;
         ol_ff        <= ol_in;
         k_ff         <= k_in;
         acyclic_ff   <= acyclic_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_u_ff       <= top_u_in;
      top_v_ff       <= top_v_in;
      row_ff         <= row_in;
      dmax_ff        <= dmax_in;
      du_ff          <= du_in;
      op_ff          <= op_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      a_ok_ff        <= a_ok_in;
      res_status_ff  <= res_status_in;
      res_reached_ff <= res_reached_in;
      res_dist_ff    <= res_dist_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_acyclic_ff <= rsp_acyclic_in;
      rsp_reached_ff <= rsp_reached_in;
      rsp_dist_ff    <= rsp_dist_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_acyclic  = rsp_acyclic_ff;
   assign rsp_reached  = rsp_reached_ff;
   assign rsp_distance = rsp_dist_ff;

   dtsl_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj (
      .clock(clock), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
      .raddr(adj_raddr), .rdata(adj_rdata));

   dtsl_ram #(.WIDTH(2), .DEPTH(NODES)) u_color (
      .clock(clock), .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
      .raddr(col_raddr), .rdata(col_rdata));

   dtsl_ram #(.WIDTH(DIST_W), .DEPTH(NODES)) u_dts (
      .clock(clock), .we(dts_we), .waddr(dts_waddr), .wdata(dts_wdata),
      .raddr(dts_raddr), .rdata(dts_rdata));

   dtsl_ram #(.WIDTH(NW), .DEPTH(NODES)) u_topo (
      .clock(clock), .we(topo_we), .waddr(topo_waddr), .wdata(topo_wdata),
      .raddr(topo_raddr), .rdata(topo_rdata));

   dtsl_ram #(.WIDTH(NW + CW), .DEPTH(NODES)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .raddr(stk_raddr), .rdata(stk_rdata));

   dtsl_ram #(.WIDTH(DIST_W + 1), .DEPTH(NODES)) u_src (
      .clock(clock), .we(src_we), .waddr(src_waddr), .wdata(src_wdata),
      .raddr(src_raddr), .rdata(src_rdata));

   `DTSL_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_ready)
   `DTSL_ASSERT_IMPL(a_stack_bound, clock, reset, 1'b1, sp_ff <= CW'(NODES))
   `DTSL_ASSERT_IMPL(a_order_bound, clock, reset, 1'b1, ol_ff <= CW'(NODES))
   `DTSL_ASSERT_IMPL(a_scan_has_top, clock, reset, state_ff == ST_S_SCAN, sp_ff != '0)

endmodule

[bench/tb_top.sv]
module tb_top;
   import dtsl_pkg::*;

   localparam int N        = 64;
   localparam int WD_LIMIT = 60000;

   // Operation codes beyond the package's six; the block ignores them.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic       status;
      logic       acyclic;
      logic       reached;
      logic [5:0] distance;
   } graph_ans_type;

   typedef struct {
      logic [2:0]    op;
      logic [5:0]    a;
      logic [5:0]    b;
      bit            typed;
      graph_ans_type ans;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic [2:0] req_op = '0;
   logic [5:0] req_node_a = '0, req_node_b = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic rsp_status, rsp_acyclic, rsp_reached;
   logic [DIST_W-1:0] rsp_distance;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   dag_topo_sort_longest_path u_top (.*);

   // Shadow copy of the graph and of everything the last sort left behind.
   bit [N-1:0] shadow_adj [N];
   bit [1:0]   shadow_color [N];
   bit [5:0]   shadow_sink_dist [N];
   bit [5:0]   shadow_order [N];
   int         shadow_order_len;
   bit         shadow_acyclic;

   graph_ans_type expected_answers [$];
   step_row_type  offered_steps [$];   // issued beats, in order, awaiting acceptance
   int            fail_count;
   int            send_idle_pct, rcv_idle_pct;
   int            hold_cycles;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("tb_top: mismatch on %s: got %0d, expected %0d", what, got, want);
      fail_count++;
   endtask

   // Depth-first search from src with an explicit stack, lowest neighbor first.
   // Finish order becomes the topological order; each finished node takes the
   // longest distance to a sink, except the very first one, which gets zero.
   function automatic void sort_graph(input int src);
      int stk_node [N];
      int stk_next [N];
      int sp, u, v, d, t;
      foreach (shadow_color[i]) shadow_color[i] = COLOR_WHITE;
      shadow_order_len = 0;
      shadow_acyclic   = 1'b1;
      shadow_color[src] = COLOR_GRAY;
      stk_node[0] = src;
      stk_next[0] = 0;
      sp = 1;
      while (sp > 0) begin
         u = stk_node[sp-1];
         v = stk_next[sp-1];
         while (v < N && !shadow_adj[u][v]) v++;
         if (v < N) begin
            stk_next[sp-1] = v + 1;
            if (shadow_color[v] == COLOR_WHITE) begin
               if (sp < N) begin
                  shadow_color[v] = COLOR_GRAY;
                  stk_node[sp] = v;
                  stk_next[sp] = 0;
                  sp++;
               end
            end else if (shadow_color[v] == COLOR_GRAY) begin
               shadow_acyclic = 1'b0;
            end
         end else begin
            d = 0;
            shadow_color[u] = COLOR_BLACK;
            // A gray neighbor still lends its older distance here.
            if (shadow_order_len != 0)
               for (int w = 0; w < N; w++)
                  if (shadow_adj[u][w]) begin
                     t = int'(shadow_sink_dist[w]) + 1;
                     if (t > 63) t = 63;
                     if (t > d) d = t;
                  end
            shadow_sink_dist[u] = d[5:0];
            if (shadow_order_len < N) begin
               shadow_order[shadow_order_len] = u[5:0];
               shadow_order_len++;
            end
            sp--;
         end
      end
   endfunction

   // Longest path from the search source over the recorded order, using the
   // edges as they stand now. Returns the answer for node q.
   function automatic graph_ans_type source_distance(input int q);
      graph_ans_type r;
      bit   seen [N];
      int   path_len [N];
      int   u, t;
      r = '0;
      foreach (seen[i]) seen[i] = 1'b0;
      u = int'(shadow_order[shadow_order_len-1]);
      seen[u] = 1'b1;
      path_len[u] = 0;
      for (int k = shadow_order_len; k > 0; k--) begin
         u = int'(shadow_order[k-1]);
         if (seen[u])
            for (int v = 0; v < N; v++)
               if (shadow_adj[u][v]) begin
                  t = path_len[u] + 1;
                  if (!seen[v] || t > path_len[v]) begin
                     seen[v] = 1'b1;
                     path_len[v] = t;
                  end
               end
      end
      if (seen[q]) begin
         r.reached  = 1'b1;
         r.distance = (path_len[q] > 63) ? 6'd63 : path_len[q][5:0];
      end
      return r;
   endfunction

   function automatic graph_ans_type graph_step(input logic [2:0] op, input logic [5:0] a,
                                                input logic [5:0] b);
      graph_ans_type r;
      r = '0;
      case (op)
         OP_ADD_EDGE:    shadow_adj[a][b] = 1'b1;
         OP_REMOVE_EDGE: shadow_adj[a][b] = 1'b0;
         OP_REMOVE_NODE: begin
            foreach (shadow_adj[i]) shadow_adj[i][a] = 1'b0;
            shadow_adj[a] = '0;
         end
         OP_SORT:        sort_graph(int'(a));
         OP_DIST_SINK:   r.distance = shadow_sink_dist[a];
         OP_DIST_SOURCE: begin
            if (shadow_order_len == 0) r.status = 1'b1;
            else r = source_distance(int'(a));
         end
         default: ;
      endcase
      r.acyclic = shadow_acyclic;
      return r;
   endfunction

   // Both monitors look at the bus at the falling edge, where everything
   // driven or updated at the rising edge has settled. A beat seen here is
   // taken at the next rising edge.
   always @(negedge clock) begin
      step_row_type  s;
      graph_ans_type p, w;
      if (!reset && req_valid && req_ready) begin
         s = offered_steps.pop_front();
         p = graph_step(req_op, req_node_a, req_node_b);
         // Rows with a typed answer are held to it; the predictor state
         // still advances so later rows stay in step.
         expected_answers.push_back(s.typed ? s.ans : p);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("result beats", 1, 0);
         end else begin
            w = expected_answers.pop_front();
            if (rsp_status !== w.status)
               report_mismatch("status", int'(rsp_status), int'(w.status));
            if (rsp_acyclic !== w.acyclic)
               report_mismatch("acyclic", int'(rsp_acyclic), int'(w.acyclic));
            if (rsp_reached !== w.reached)
               report_mismatch("reached", int'(rsp_reached), int'(w.reached));
            if (rsp_distance !== w.distance)
               report_mismatch("distance", int'(rsp_distance), int'(w.distance));
         end
      end
   end

   // The receiver. A requested hold keeps ready low for a long stretch so the
   // block fills its output register and then stalls the input side.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // Watchdog: cycles in a row with no beat on either channel.
   int quiet_cycles;
   always @(negedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("tb_top: watchdog expired");
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Offers one beat, with a random gap first, and returns once it is taken.
   // Valid stays high from one beat straight into the next when no gap falls.
   task automatic send_step(input logic [2:0] op, input logic [5:0] a, input logic [5:0] b,
                            input bit typed = 1'b0, input graph_ans_type ans = '0);
      step_row_type s;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      s.op = op; s.a = a; s.b = b; s.typed = typed; s.ans = ans;
      offered_steps.push_back(s);
      req_valid  <= 1'b1;
      req_op     <= op;
      req_node_a <= a;
      req_node_b <= b;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   // A well-formed burst: edges among a handful of nodes, a sort from one of
   // them, then queries, with an occasional edit after the sort.
   task automatic graph_burst();
      logic [5:0] pool [6];
      int k;
      foreach (pool[i]) pool[i] = 6'($urandom_range(63));
      k = $urandom_range(3, 9);
      repeat (k) send_step(OP_ADD_EDGE, pool[$urandom_range(5)], pool[$urandom_range(5)]);
      if ($urandom_range(3) == 0) send_step(OP_REMOVE_EDGE, pool[$urandom_range(5)],
                                            pool[$urandom_range(5)]);
      send_step(OP_SORT, pool[$urandom_range(5)], 6'($urandom_range(63)));
      repeat (2) send_step(OP_DIST_SINK, pool[$urandom_range(5)], 6'($urandom_range(63)));
      if ($urandom_range(2) == 0) send_step(OP_ADD_EDGE, pool[$urandom_range(5)],
                                            pool[$urandom_range(5)]);
      send_step(OP_DIST_SOURCE, pool[$urandom_range(5)], 6'($urandom_range(63)));
      if ($urandom_range(4) == 0) send_step(OP_REMOVE_NODE, pool[$urandom_range(5)], 6'd0);
   endtask

   function automatic graph_ans_type typed_ans(input bit st, input bit acy, input bit rch,
                                               input int len);
      graph_ans_type r;
      r.status = st; r.acyclic = acy; r.reached = rch; r.distance = len[5:0];
      return r;
   endfunction

   step_row_type directed_rows [$];
   int           sent;

   initial begin
      foreach (shadow_adj[i]) begin
         shadow_adj[i] = '0;
         shadow_color[i] = COLOR_WHITE;
         shadow_sink_dist[i] = '0;
         shadow_order[i] = '0;
      end
      shadow_order_len = 0;
      shadow_acyclic   = 1'b0;
      fail_count = 0;
      hold_cycles = 0;
      send_idle_pct = 19;
      rcv_idle_pct  = 78;

      // Directed rows: a source query before any sort reports not sorted,
      // the spare codes do nothing, then a small graph with extreme node
      // numbers, a cycle, edits after a sort and an unreached node.
      directed_rows = '{
         '{OP_DIST_SOURCE, 6'd0,  6'd0,  1'b1, typed_ans(1, 0, 0, 0)},
         '{OP_DIST_SINK,   6'd63, 6'd63, 1'b1, typed_ans(0, 0, 0, 0)},
         '{OP_SPARE_6,     6'd63, 6'd63, 1'b1, typed_ans(0, 0, 0, 0)},
         '{OP_SPARE_7,     6'd21, 6'd42, 1'b1, typed_ans(0, 0, 0, 0)},
         '{OP_ADD_EDGE,    6'd0,  6'd63, 1'b1, typed_ans(0, 0, 0, 0)},
         '{OP_ADD_EDGE,    6'd63, 6'd5,  1'b0, '0},
         '{OP_ADD_EDGE,    6'd0,  6'd5,  1'b0, '0},
         '{OP_ADD_EDGE,    6'd5,  6'd62, 1'b0, '0},
         '{OP_SORT,        6'd0,  6'd0,  1'b0, '0},
         '{OP_DIST_SINK,   6'd0,  6'd0,  1'b0, '0},
         '{OP_DIST_SOURCE, 6'd62, 6'd0,  1'b0, '0},
         '{OP_DIST_SOURCE, 6'd7,  6'd0,  1'b0, '0},
         '{OP_ADD_EDGE,    6'd62, 6'd0,  1'b0, '0},
         '{OP_SORT,        6'd0,  6'd0,  1'b0, '0},
         '{OP_DIST_SINK,   6'd62, 6'd0,  1'b0, '0},
         '{OP_REMOVE_EDGE, 6'd62, 6'd0,  1'b0, '0},
         '{OP_DIST_SOURCE, 6'd62, 6'd0,  1'b0, '0},
         '{OP_REMOVE_NODE, 6'd63, 6'd63, 1'b0, '0},
         '{OP_DIST_SOURCE, 6'd63, 6'd0,  1'b0, '0},
         '{OP_SORT,        6'd63, 6'd0,  1'b0, '0},
         '{OP_DIST_SINK,   6'd63, 6'd0,  1'b0, '0},
         '{OP_DIST_SOURCE, 6'd63, 6'd0,  1'b0, '0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_step(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                   directed_rows[i].typed, directed_rows[i].ans);

      // Random part in three idling phases. The second opens with a long
      // receiver hold while the sender keeps offering beats.
      sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 78;
            rcv_idle_pct  = 19;
            hold_cycles   = 400;
            repeat (6) send_step(OP_DIST_SINK, 6'($urandom_range(63)),
                                 6'($urandom_range(63)));
            sent += 6;
         end
         if (phase == 2) begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         while (sent < 40 * (phase + 1)) begin
            if ($urandom_range(3) != 0) begin
               graph_burst();
               sent += 10;
            end else begin
               send_step(3'($urandom_range(7)), 6'($urandom_range(63)),
                         6'($urandom_range(63)));
               sent++;
            end
         end
      end
      req_valid <= 1'b0;

      while (expected_answers.size() != 0 || offered_steps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      if (fail_count == 0 && expected_answers.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
